[rtl/directory_free_map_scan_top_macros.svh]
// Assertion helpers shared by the RTL of the directory free map scanner.
`ifndef DIRECTORY_FREE_MAP_SCAN_TOP_MACROS_SVH
`define DIRECTORY_FREE_MAP_SCAN_TOP_MACROS_SVH

// Condition holds at every clock edge out of reset.
`define DFMS_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define DFMS_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define DFMS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/dfms_pkg.sv]
package dfms_pkg;

	localparam int DIR_ENTRIES_DEF = 32;
	localparam int MAP_BLOCKS_DEF  = 256;

	// action codes
	localparam logic [1:0] ACT_START = 2'd0;
	localparam logic [1:0] ACT_BYTE  = 2'd1;
	localparam logic [1:0] ACT_QUERY = 2'd2;

	// result kinds
	localparam logic KIND_LIST = 1'b0;
	localparam logic KIND_FREE = 1'b1;

	// byte offsets of interest within an extent
	localparam logic [4:0] OFF_STATUS = 5'd0;
	localparam logic [4:0] OFF_BC     = 5'd13;
	localparam logic [4:0] OFF_RC     = 5'd15;
	localparam logic [4:0] OFF_LAST   = 5'd31;

	localparam logic [7:0]  DELETED_MARK = 8'hE5;
	localparam logic [16:0] BLOCK_BYTES  = 17'd1024;

	localparam int ENTRY_W = 5;
	localparam int OFFS_W  = 5;
	localparam int BYTE_W  = 8;
	localparam int SIZE_W  = 16;
	localparam int PCNT_W  = 5;

	typedef struct packed {
		logic [BYTE_W-1:0]  query_block;
		logic [BYTE_W-1:0]  data_byte;
		logic [OFFS_W-1:0]  byte_offset;
		logic [ENTRY_W-1:0] entry_number;
	} in_fields_t;

endpackage

[rtl/directory_free_map_scan_top.sv]
// Directory free map scanner: walks a CP/M directory one byte per beat and keeps a
// map of which disk blocks are free.
// Slave stream: s_axis_tuser carries the action (start scan, directory byte, free map
// query); s_axis_tdata carries extent number, byte offset, byte value and query block.
// A start beat marks every block free except block 0 and clears the extent fields.
// Directory bytes update status, BC, RC and the block pointers; the byte at offset 31
// of an extent gives one listing beat (live flag, size). A query gives one answer beat.
// Master stream: m_axis_tuser is the result kind, m_axis_tdata the result fields.
// A result is registered in the input register, then in the result register, after
// its input beat is taken. One beat per cycle is sustained unless a result beat waits
// on a stalled receiver, since every update is a single pass of narrow logic over the map flops.
// When the receiver stalls, the result register holds; a following beat that gives
// no result still passes, one that gives a result waits in the input register, and
// s_axis_tready drops only while that beat waits.
// Reset (arst_n low) empties both registers and puts the map and extent fields in the
// same state as a start beat.
module directory_free_map_scan_top #(
	parameter int DIR_ENTRIES = dfms_pkg::DIR_ENTRIES_DEF,
	parameter int MAP_BLOCKS  = dfms_pkg::MAP_BLOCKS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [4:0] entry_number, [9:5] byte_offset, [17:10] data_byte, [25:18] query_block
	input  logic [31:0] s_axis_tdata,
	// [1:0] action
	input  logic [1:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [4:0] listed_entry, [5] entry_live, [21:6] file_bytes, [22] block_free
	output logic [23:0] m_axis_tdata,
	// [0] result_kind
	output logic [0:0]  m_axis_tuser
);

`include "directory_free_map_scan_top_macros.svh"

	localparam logic [MAP_BLOCKS-1:0] MapInit = MAP_BLOCKS'(1);
	localparam logic [6:0] DirLimit = 7'(DIR_ENTRIES);
	localparam logic [8:0] MapLimit = 9'(MAP_BLOCKS);

	// input register
	logic                 valid_s1;
	logic [1:0]           action_s1;
	dfms_pkg::in_fields_t fields_s1;

	// scan state
	logic [MAP_BLOCKS-1:0]          used_q;
	logic [7:0]                     status_q;
	logic [dfms_pkg::PCNT_W-1:0]    ptr_cnt_q;
	logic [7:0]                     bc_q;
	logic [7:0]                     rc_q;

	// result register
	logic                           out_valid_q;
	logic                           out_kind_q;
	logic [dfms_pkg::ENTRY_W-1:0]   out_entry_q;
	logic                           out_live_q;
	logic [dfms_pkg::SIZE_W-1:0]    out_bytes_q;
	logic                           out_free_q;

	logic                           byte_hit;
	logic                           has_res;
	logic                           s1_go;
	logic                           mark;
	logic [MAP_BLOCKS-1:0]          used_n;
	logic [7:0]                     status_n;
	logic [dfms_pkg::PCNT_W-1:0]    ptr_cnt_n;
	logic [7:0]                     bc_n;
	logic [7:0]                     rc_n;
	logic                           q_used;
	logic                           q_free;
	logic                           live;
	logic [16:0]                    raw_size;
	logic [dfms_pkg::SIZE_W-1:0]    size;

	assign byte_hit = valid_s1 && (action_s1 == dfms_pkg::ACT_BYTE)
		&& (7'(fields_s1.entry_number) < DirLimit);
	assign has_res = valid_s1 && ((action_s1 == dfms_pkg::ACT_QUERY)
		|| (byte_hit && (fields_s1.byte_offset == dfms_pkg::OFF_LAST)));
	assign s1_go = valid_s1 && (!has_res || !out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || s1_go;

	always_comb begin
		status_n  = status_q;
		ptr_cnt_n = ptr_cnt_q;
		bc_n      = bc_q;
		rc_n      = rc_q;
		mark      = 1'b0;
		if (byte_hit) begin
			case (fields_s1.byte_offset)
				dfms_pkg::OFF_STATUS: begin
					status_n  = fields_s1.data_byte;
					ptr_cnt_n = '0;
					bc_n      = '0;
					rc_n      = '0;
				end
				dfms_pkg::OFF_BC: bc_n = fields_s1.data_byte;
				dfms_pkg::OFF_RC: rc_n = fields_s1.data_byte;
				default: begin
					if (fields_s1.byte_offset[4] && (fields_s1.data_byte != 8'd0)) begin
						ptr_cnt_n = ptr_cnt_q + 1'b1;
						mark      = 1'b1;
					end
				end
			endcase
		end
	end

	// mark the pointed block used; pointers beyond the map match no flop
	always_comb begin
		used_n = used_q;
		for (int i = 0; i < MAP_BLOCKS; i++) begin
			if (mark && (fields_s1.data_byte == 8'(i))) begin
				used_n[i] = 1'b1;
			end
		end
	end

	always_comb begin
		q_used = 1'b1;
		for (int i = 0; i < MAP_BLOCKS; i++) begin
			if (fields_s1.query_block == 8'(i)) begin
				q_used = used_q[i];
			end
		end
		q_free = !q_used && ({1'b0, fields_s1.query_block} < MapLimit);
	end

	// size = pointers*1024 + RC*128 + BC - 1024, clamped at zero; zero for a deleted extent
	assign live = (status_n != dfms_pkg::DELETED_MARK);
	assign raw_size = {2'b00, ptr_cnt_n, 10'b0} + {2'b00, rc_n, 7'b0} + 17'(bc_n);
	assign size = (!live || (raw_size < dfms_pkg::BLOCK_BYTES)) ? '0
		: 16'(raw_size - dfms_pkg::BLOCK_BYTES);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tvalid && s_axis_tready) begin
			valid_s1 <= 1'b1;
		end else if (s1_go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			action_s1 <= s_axis_tuser;
			fields_s1 <= s_axis_tdata[25:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q    <= MapInit;
			status_q  <= '0;
			ptr_cnt_q <= '0;
			bc_q      <= '0;
			rc_q      <= '0;
		end else if (s1_go) begin
			if (action_s1 == dfms_pkg::ACT_START) begin
				used_q    <= MapInit;
				status_q  <= '0;
				ptr_cnt_q <= '0;
				bc_q      <= '0;
				rc_q      <= '0;
			end else begin
				used_q    <= used_n;
				status_q  <= status_n;
				ptr_cnt_q <= ptr_cnt_n;
				bc_q      <= bc_n;
				rc_q      <= rc_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_go && has_res) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && has_res) begin
			if (action_s1 == dfms_pkg::ACT_QUERY) begin
				out_kind_q  <= dfms_pkg::KIND_FREE;
				out_entry_q <= '0;
				out_live_q  <= 1'b0;
				out_bytes_q <= '0;
				out_free_q  <= q_free;
			end else begin
				out_kind_q  <= dfms_pkg::KIND_LIST;
				out_entry_q <= fields_s1.entry_number;
				out_live_q  <= live;
				out_bytes_q <= size;
				out_free_q  <= 1'b0;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_kind_q;
	assign m_axis_tdata  = {1'b0, out_free_q, out_bytes_q, out_live_q, out_entry_q};

	`DFMS_ASSERT_ALWAYS(a_blk0_used, used_q[0], "block 0 shows as free")
	`DFMS_ASSERT_NEXT(a_start_clears,
		s1_go && (action_s1 == dfms_pkg::ACT_START), used_q == MapInit,
		"start beat did not reset the free map")
	`DFMS_ASSERT_NEXT(a_s1_hold, valid_s1 && !s1_go,
		valid_s1 && $stable(fields_s1) && $stable(action_s1),
		"waiting beat lost from input register")
	`DFMS_ASSERT_SAME(a_list_fields,
		out_valid_q && (out_kind_q == dfms_pkg::KIND_LIST),
		!out_free_q && (out_live_q || (out_bytes_q == '0)),
		"listing beat carries a free bit or a size for a dead extent")
	`DFMS_ASSERT_SAME(a_free_fields,
		out_valid_q && (out_kind_q == dfms_pkg::KIND_FREE),
		(out_entry_q == '0) && !out_live_q && (out_bytes_q == '0),
		"free map answer carries listing fields")

endmodule

[dv/tb.sv]
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] ACT_UNUSED   = 2'd3;
	localparam int         RECORD_SIZE  = 128;
	localparam int         ALLOC_BYTES  = 1024;
	localparam int         OFF_PTR_BASE = 16;
	localparam int         BEAT_TARGET  = 1150;
	localparam int         LONG_HOLD    = 250;
	localparam int         STUCK_LIMIT  = 2000;
	localparam int         DRAIN_CYCLES = 8;

	typedef struct {
		logic [1:0]           action;
		dfms_pkg::in_fields_t f;
	} dir_beat_t;

	typedef struct {
		logic        kind;
		logic [4:0]  entry;
		logic        live;
		logic [15:0] bytes;
		logic        free;
	} scan_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata = '0;
	logic [1:0]  s_axis_tuser = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;
	logic [0:0]  m_axis_tuser;

	directory_free_map_scan_top u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	dir_beat_t    pending_beats[$];
	scan_result_t expected_results[$];

	// shadow of the block's map and current extent
	bit [dfms_pkg::MAP_BLOCKS_DEF-1:0] free_blocks;
	logic [7:0]                        ext_status;
	logic [4:0]                        ext_pointers;
	logic [7:0]                        ext_bc;
	logic [7:0]                        ext_rc;

	int errors = 0;
	int beats_taken = 0;
	int listings_seen = 0;
	int live_listings = 0;
	int answers_seen = 0;
	int free_answers = 0;
	int results_seen = 0;
	int stuck_cycles = 0;

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic int unsigned pick_gap(bit calm);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (calm || r < 55)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 12);
		else
			return $urandom_range(20, 40);
	endfunction

	function automatic void clear_scan();
		free_blocks    = '1;
		free_blocks[0] = 1'b0;
		ext_status     = '0;
		ext_pointers   = '0;
		ext_bc         = '0;
		ext_rc         = '0;
	endfunction

	// Update the shadow state for one beat and queue the result it gives, if any.
	function automatic void scan_directory_beat(dir_beat_t b);
		scan_result_t r;
		int           sz;
		logic [7:0]   v;
		logic [4:0]   off;
		v   = b.f.data_byte;
		off = b.f.byte_offset;
		r   = '{kind: dfms_pkg::KIND_FREE, entry: '0, live: 1'b0, bytes: '0, free: 1'b0};
		case (b.action)
			dfms_pkg::ACT_START: clear_scan();
			dfms_pkg::ACT_QUERY: begin
				if (int'(b.f.query_block) < dfms_pkg::MAP_BLOCKS_DEF)
					r.free = free_blocks[b.f.query_block];
				expected_results.push_back(r);
			end
			dfms_pkg::ACT_BYTE: begin
				if (int'(b.f.entry_number) < dfms_pkg::DIR_ENTRIES_DEF) begin
					if (off == dfms_pkg::OFF_STATUS) begin
						ext_status   = v;
						ext_pointers = '0;
						ext_bc       = '0;
						ext_rc       = '0;
					end else if (off == dfms_pkg::OFF_BC) begin
						ext_bc = v;
					end else if (off == dfms_pkg::OFF_RC) begin
						ext_rc = v;
					end else if (int'(off) >= OFF_PTR_BASE && v != 8'd0) begin
						if (int'(v) < dfms_pkg::MAP_BLOCKS_DEF)
							free_blocks[v] = 1'b0;
						ext_pointers = ext_pointers + 5'd1;
					end
					if (off == dfms_pkg::OFF_LAST) begin
						r.kind  = dfms_pkg::KIND_LIST;
						r.entry = b.f.entry_number;
						r.live  = (ext_status != dfms_pkg::DELETED_MARK);
						sz = (int'(ext_pointers) - 1) * ALLOC_BYTES
							+ int'(ext_rc) * RECORD_SIZE + int'(ext_bc);
						if (sz < 0 || !r.live)
							sz = 0;
						r.bytes = sz[15:0];
						expected_results.push_back(r);
					end
				end
			end
			default: ;
		endcase
	endfunction

	task automatic check_field(string name, int want, int got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, actual %0d", name, want, got);
			errors++;
		end
	endtask

	task automatic push_beat(logic [1:0] act, int entry, int off, int value, int qblock);
		dir_beat_t b;
		b.action         = act;
		b.f.entry_number = entry[4:0];
		b.f.byte_offset  = off[4:0];
		b.f.data_byte    = value[7:0];
		b.f.query_block  = qblock[7:0];
		pending_beats.push_back(b);
	endtask

	task automatic push_query(int qblock);
		push_beat(dfms_pkg::ACT_QUERY, $urandom_range(0, 31), $urandom_range(0, 31),
			$urandom_range(0, 255), qblock);
	endtask

	// One extent with random content; a sparse one skips about half of the bytes other than status and the last.
	task automatic add_extent(bit sparse);
		int entry;
		int status;
		int value;
		bit empty;
		entry  = $urandom_range(0, 31);
		status = ($urandom_range(0, 3) == 0) ? int'(dfms_pkg::DELETED_MARK)
			: $urandom_range(0, 255);
		empty  = ($urandom_range(0, 7) == 0);
		for (int off = 0; off < 32; off++) begin
			if (sparse && off != int'(dfms_pkg::OFF_STATUS)
					&& off != int'(dfms_pkg::OFF_LAST)
					&& $urandom_range(0, 1) == 0)
				continue;
			if (off == int'(dfms_pkg::OFF_STATUS))
				value = status;
			else if (off == int'(dfms_pkg::OFF_BC) || off == int'(dfms_pkg::OFF_RC))
				value = empty ? $urandom_range(0, 3) : $urandom_range(0, 255);
			else if (off >= OFF_PTR_BASE)
				value = (empty || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 255);
			else
				value = $urandom_range(0, 255);
			push_beat(dfms_pkg::ACT_BYTE, entry, off, value, $urandom_range(0, 255));
			if ($urandom_range(0, 19) == 0)
				push_query($urandom_range(0, 255));
		end
	endtask

	// Source side
	bit          src_calm = 1'b0;
	int unsigned src_gap  = 0;

	always @(posedge clk or negedge arst_n) begin : drive_proc
		dir_beat_t b;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
			s_axis_tuser  <= '0;
			src_gap       <= 0;
		end else if (!s_axis_tvalid || s_axis_tready) begin
			if (src_gap != 0) begin
				src_gap       <= src_gap - 1;
				s_axis_tvalid <= 1'b0;
			end else if (pending_beats.size() != 0) begin
				b = pending_beats.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tdata  <= {6'b0, b.f};
				s_axis_tuser  <= b.action;
				src_gap       <= pick_gap(src_calm);
				if ($urandom_range(0, 149) == 0)
					src_calm <= !src_calm;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// Sink side: random stalls, plus two long hold-offs to back the block up
	bit          sink_calm = 1'b0;
	int unsigned sink_stall = 0;
	int unsigned hold_left = 0;
	int          holds_done = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			sink_stall    <= 0;
			hold_left     <= 0;
		end else if (hold_left == 0 && holds_done < 2
				&& results_seen >= 40 + 100 * holds_done) begin
			hold_left     <= LONG_HOLD;
			holds_done    <= holds_done + 1;
			m_axis_tready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left     <= hold_left - 1;
			m_axis_tready <= 1'b0;
		end else if (sink_stall != 0) begin
			sink_stall    <= sink_stall - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
			if ($urandom_range(0, 5) == 0)
				sink_stall <= pick_gap(sink_calm);
			if ($urandom_range(0, 199) == 0)
				sink_calm <= !sink_calm;
		end
	end

	// Check results against the predicted queue, then predict for the input beat
	always @(posedge clk) begin : check_proc
		scan_result_t got;
		scan_result_t want;
		dir_beat_t    b;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.kind  = m_axis_tuser[0];
				got.entry = m_axis_tdata[4:0];
				got.live  = m_axis_tdata[5];
				got.bytes = m_axis_tdata[21:6];
				got.free  = m_axis_tdata[22];
				results_seen <= results_seen + 1;
				if (got.kind == dfms_pkg::KIND_LIST) begin
					listings_seen++;
					if (got.live)
						live_listings++;
				end else begin
					answers_seen++;
					if (got.free)
						free_answers++;
				end
				if (expected_results.size() == 0) begin
					$error("result beat with nothing expected: kind %0d data 0x%06h",
						got.kind, m_axis_tdata);
					errors++;
				end else begin
					want = expected_results.pop_front();
					check_field("result_kind", want.kind, got.kind);
					check_field("listed_entry", want.entry, got.entry);
					check_field("entry_live", want.live, got.live);
					check_field("file_bytes", want.bytes, got.bytes);
					check_field("block_free", want.free, got.free);
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				b.action = s_axis_tuser;
				b.f      = s_axis_tdata[25:0];
				beats_taken++;
				scan_directory_beat(b);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
				stuck_cycles <= 0;
			end else if (stuck_cycles >= STUCK_LIMIT) begin
				$display("timeout: no beat moved for %0d cycles", STUCK_LIMIT);
				$display("*** FAILED ***");
				$finish;
			end else begin
				stuck_cycles <= stuck_cycles + 1;
			end
		end
	end

	initial begin
		int r;
		clear_scan();

		// directed: map extremes, unused bytes, zero pointer, dead extent, size clamp
		push_beat(dfms_pkg::ACT_START, 0, 0, 0, 0);
		push_beat(ACT_UNUSED, 31, 31, 255, 255);
		push_query(0);
		push_query(255);
		push_beat(dfms_pkg::ACT_BYTE, 31, 0, 'h00, 0);
		push_beat(dfms_pkg::ACT_BYTE, 31, 1, 'hFF, 255);
		push_beat(dfms_pkg::ACT_BYTE, 31, 13, 'hFF, 0);
		push_beat(dfms_pkg::ACT_BYTE, 31, 14, 'hAA, 0);
		push_beat(dfms_pkg::ACT_BYTE, 31, 15, 'hFF, 0);
		push_beat(dfms_pkg::ACT_BYTE, 31, 16, 'hFF, 0);
		push_beat(dfms_pkg::ACT_BYTE, 31, 17, 'h00, 0);
		push_beat(dfms_pkg::ACT_BYTE, 31, 20, 'h01, 0);
		push_beat(dfms_pkg::ACT_BYTE, 31, 31, 'h80, 0);
		push_query(255);
		push_query(1);
		push_query(128);
		push_beat(dfms_pkg::ACT_BYTE, 0, 0, int'(dfms_pkg::DELETED_MARK), 0);
		push_beat(dfms_pkg::ACT_BYTE, 0, 16, 'h07, 0);
		push_beat(dfms_pkg::ACT_BYTE, 0, 31, 'h00, 0);
		push_query(7);
		push_beat(dfms_pkg::ACT_BYTE, 5, 0, 'h21, 0);
		push_beat(dfms_pkg::ACT_BYTE, 5, 31, 'h00, 0);
		push_beat(dfms_pkg::ACT_START, 0, 0, 0, 0);
		push_query(255);
		push_query(0);

		// random: mostly whole extents, some sparse ones, start beats, queries and noise
		while (pending_beats.size() < BEAT_TARGET) begin
			r = $urandom_range(0, 99);
			if (r < 8) begin
				push_beat(dfms_pkg::ACT_START, $urandom_range(0, 31), $urandom_range(0, 31),
					$urandom_range(0, 255), $urandom_range(0, 255));
			end else if (r < 68) begin
				add_extent(1'b0);
			end else if (r < 82) begin
				add_extent(1'b1);
			end else if (r < 92) begin
				repeat ($urandom_range(1, 4))
					push_query($urandom_range(0, 255));
			end else begin
				repeat ($urandom_range(1, 6))
					push_beat(2'($urandom_range(0, 3)), $urandom_range(0, 31),
						$urandom_range(0, 31), $urandom_range(0, 255),
						$urandom_range(0, 255));
			end
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_beats.size() != 0 || s_axis_tvalid)
			@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d beats; got %0d extent listings (%0d live)",
			beats_taken, listings_seen, live_listings);
		$display("and %0d map answers (%0d free); receiver held off %0d times for %0d cycles.",
			answers_seen, free_answers, holds_done, LONG_HOLD);
		if (errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("%0d mismatches", errors);
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

[filelist.f]
+incdir+rtl
rtl/dfms_pkg.sv
rtl/directory_free_map_scan_top.sv
dv/tb.sv
